/* design/gst_pkg.sv */
// shared constants, types and decode helpers for the gpio/spi/timer register block
package gst_pkg;

    localparam int PORT_COUNT     = 2;
    localparam int SPI_DONE_TICKS = 3;
    localparam int SPI_CNT_W      = $clog2(SPI_DONE_TICKS + 1);
    localparam int REGS_PER_PORT  = 5;

    localparam logic [3:0] SEL_IRQ        = 4'd0;
    localparam logic [3:0] SEL_PORT_FIRST = 4'd1;
    localparam logic [3:0] SEL_PORT_LAST  = 4'd10;
    localparam logic [3:0] SEL_SPI_DATA   = 4'd11;
    localparam logic [3:0] SEL_SPI_STATUS = 4'd12;

    localparam logic [7:0] SPI_DONE_STATUS = 8'h80;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_TICK  = 2'd2
    } gst_mode_t;

    typedef enum logic [2:0] {
        FN_CLR  = 3'd0,
        FN_SET  = 3'd1,
        FN_PIN  = 3'd2,
        FN_DIR  = 3'd3,
        FN_MASK = 3'd4
    } gst_fn_t;

    // one decoded transaction as seen by the register units
    typedef struct packed {
        logic        en;
        logic        rd;
        logic        wr;
        logic        tick;
        logic [3:0]  sel;
        logic [31:0] wdata;
    } gst_op_t;

    // port number of a gpio selector (selectors 1..10 only)
    function automatic logic gst_port_idx(input logic [3:0] sel);
        logic [3:0] rel;
        rel = sel - SEL_PORT_FIRST;
        return (rel >= 4'(REGS_PER_PORT));
    endfunction

    // register within the port for a gpio selector
    function automatic gst_fn_t gst_port_fn(input logic [3:0] sel);
        logic [3:0] rel;
        logic [3:0] k;
        rel = sel - SEL_PORT_FIRST;
        k   = (rel >= 4'(REGS_PER_PORT)) ? rel - 4'(REGS_PER_PORT) : rel;
        return gst_fn_t'(k[2:0]);
    endfunction

endpackage

/* design/gst_gpio_port.sv */
// one fast gpio port: output, direction and protect mask registers
module gst_gpio_port
    import gst_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  gst_op_t     op,
    input  logic        hit,
    output logic [31:0] rdata
);

    logic [31:0] out_reg, out_next;
    logic [31:0] mask_reg, mask_next;
    logic [31:0] dir_reg, dir_next;
    logic [31:0] open_bits;
    gst_fn_t     fn;

    assign fn        = gst_port_fn(op.sel);
    assign open_bits = op.wdata & ~mask_reg;

    always_comb begin
        out_next  = out_reg;
        mask_next = mask_reg;
        dir_next  = dir_reg;
        if (op.en && op.wr && hit) begin
            unique case (fn)
                FN_CLR:  out_next  = out_reg & ~open_bits;
                FN_SET:  out_next  = out_reg | open_bits;
                FN_PIN:  out_next  = (out_reg & mask_reg) | open_bits;
                FN_DIR:  dir_next  = op.wdata;
                FN_MASK: mask_next = op.wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        rdata = '0;
        if (hit) begin
            unique case (fn)
                FN_CLR, FN_SET, FN_PIN: rdata = out_reg & ~mask_reg;
                FN_DIR:                 rdata = dir_reg;
                FN_MASK:                rdata = mask_reg;
                default:                rdata = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg  <= '0;
            mask_reg <= '0;
            dir_reg  <= '0;
        end else begin
            out_reg  <= out_next;
            mask_reg <= mask_next;
            dir_reg  <= dir_next;
        end
    end

endmodule

/* design/gst_spi_timer.sv */
// timer irq flag and spi data/status registers with transfer tick counter
module gst_spi_timer
    import gst_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  gst_op_t     op,
    output logic [31:0] rdata,
    output logic        bad
);

    logic                 irq_reg, irq_next;
    logic [31:0]          shift_reg, shift_next;
    logic                 busy_reg, busy_next;
    logic [SPI_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SPI_CNT_W-1:0] cnt_inc;
    logic [7:0]           status_reg, status_next;

    assign cnt_inc = cnt_reg + SPI_CNT_W'(1);
    assign bad     = op.wr && (op.sel == SEL_SPI_STATUS);

    always_comb begin
        priority if (op.sel == SEL_IRQ)             rdata = {31'd0, irq_reg};
        else if (op.sel == SEL_SPI_DATA)            rdata = shift_reg;
        else if (op.sel == SEL_SPI_STATUS)          rdata = {24'd0, status_reg};
        else                                        rdata = '0;
    end

    always_comb begin
        irq_next    = irq_reg;
        shift_next  = shift_reg;
        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        if (op.en) begin
            if (op.rd && op.sel == SEL_SPI_STATUS) begin
                status_next = '0;
            end
            if (op.wr && op.sel == SEL_IRQ && op.wdata[0]) begin
                irq_next = 1'b0;
            end
            if (op.wr && op.sel == SEL_SPI_DATA) begin
                shift_next = op.wdata;
                busy_next  = 1'b1;
                cnt_next   = '0;
            end
            if (op.tick) begin
                if (busy_reg) begin
                    if (cnt_inc == SPI_CNT_W'(SPI_DONE_TICKS)) begin
                        busy_next   = 1'b0;
                        cnt_next    = '0;
                        status_next = SPI_DONE_STATUS;
                    end else begin
                        cnt_next = cnt_inc;
                    end
                end
                irq_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            irq_reg    <= 1'b0;
            shift_reg  <= '0;
            busy_reg   <= 1'b0;
            cnt_reg    <= '0;
            status_reg <= '0;
        end else begin
            irq_reg    <= irq_next;
            shift_reg  <= shift_next;
            busy_reg   <= busy_next;
            cnt_reg    <= cnt_next;
            status_reg <= status_next;
        end
    end

endmodule

/* design/gpio_spi_timer_register_model.sv */
// top level of the gpio/spi/timer register block
//
// Each input transaction is a bus read, a bus write or a time tick, and gives
// exactly one result transaction (read data and a bad-access flag). The block
// takes one transaction per cycle while the result side is not stalled: a
// transaction is captured in the input register, then acts on the register
// state and forms its result as it moves into the result register, which
// raises m_valid; sustained throughput is one transaction per clock while
// m_ready stays high. s_ready drops only when the input register holds a
// transaction and the result register is full and not being taken. Two gpio
// ports hold output, direction and protect mask registers; set, clear and pin
// writes act on unmasked bits only and reads of them return the output with
// masked bits zeroed. Every tick sets the timer irq flag (write 1 to bit 0 to
// clear). A write to spi data starts a transfer that sets spi status to 0x80
// after three ticks; reading spi status clears it; writing it returns
// bad_access.
module gpio_spi_timer_register_model
    import gst_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [3:0]  s_reg_select,
    input  logic [31:0] s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data,
    output logic        m_bad_access
);

    // input register
    logic        in_vld_reg;
    logic [1:0]  mode_reg;
    logic [3:0]  sel_reg;
    logic [31:0] wdata_reg;

    // result register
    logic        out_vld_reg;
    logic [31:0] rdata_reg, rdata_next;
    logic        bad_reg, bad_next;

    logic        out_free;
    logic        advance;
    gst_op_t     op;
    logic        port_range;
    logic        port_idx;

    logic [31:0]           port_rdata [PORT_COUNT];
    logic [PORT_COUNT-1:0] port_hit;
    logic [31:0]           port_rdata_any;
    logic [31:0]           st_rdata;
    logic                  st_bad;

    // result slot is free when empty or being drained this cycle
    assign out_free = !out_vld_reg || m_ready;
    assign advance  = in_vld_reg && out_free;
    assign s_ready  = !in_vld_reg || out_free;

    // decode the held transaction; state changes only as it advances
    always_comb begin
        op       = '0;
        op.en    = advance;
        op.sel   = sel_reg;
        op.wdata = wdata_reg;
        unique case (mode_reg)
            MODE_READ:  op.rd   = 1'b1;
            MODE_WRITE: op.wr   = 1'b1;
            MODE_TICK:  op.tick = 1'b1;
            default:    ;
        endcase
    end

    assign port_range = (sel_reg >= SEL_PORT_FIRST) && (sel_reg <= SEL_PORT_LAST);
    assign port_idx   = gst_port_idx(sel_reg);

    // one register set per port; ports past the second are never addressed
    for (genvar i = 0; i < PORT_COUNT; i++) begin : g_port
        assign port_hit[i] = port_range && (32'(port_idx) == 32'(i));

        gst_gpio_port u_port (
            .aclk    (aclk),
            .aresetn (aresetn),
            .op      (op),
            .hit     (port_hit[i]),
            .rdata   (port_rdata[i])
        );
    end

    always_comb begin
        port_rdata_any = '0;
        for (int i = 0; i < PORT_COUNT; i++) begin
            port_rdata_any = port_rdata_any | port_rdata[i];
        end
    end

    gst_spi_timer u_spi_timer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (op),
        .rdata   (st_rdata),
        .bad     (st_bad)
    );

    // read data only for reads; both units drive zero when not addressed
    assign rdata_next = op.rd ? (port_rdata_any | st_rdata) : '0;
    assign bad_next   = st_bad;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mode_reg  <= s_mode;
            sel_reg   <= s_reg_select;
            wdata_reg <= s_write_data;
        end
        if (advance) begin
            rdata_reg <= rdata_next;
            bad_reg   <= bad_next;
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_read_data  = rdata_reg;
    assign m_bad_access = bad_reg;

    // a bad access is a write, so it never carries read data
    a_bad_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_access |-> m_read_data == 32'd0)
        else $error("bad access result carries read data");

    // a transaction leaving the input register always lands in the result slot
    a_advance_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_vld_reg)
        else $error("advanced transaction lost");

    // a held transaction blocked by a full result slot keeps its payload
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !out_free |=> in_vld_reg && $stable(sel_reg) && $stable(mode_reg))
        else $error("blocked transaction dropped or changed");

    // only one port register set may be addressed at once
    a_port_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |-> $onehot0(port_hit))
        else $error("more than one gpio port addressed");

endmodule

/* tb/gpio_spi_timer_register_model_test.sv */
// self-checking testbench for the gpio/spi/timer register block: directed table, then random traffic
`timescale 1ns / 1ps

module gpio_spi_timer_register_model_test;
    import gst_pkg::*;

    // codes the package does not name
    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam logic [3:0] SEL_UNUSED_LO = 4'd13;
    localparam logic [3:0] SEL_UNUSED_HI = 4'd15;

    // gpio selectors, port 0 then port 1, each in clear/set/pin/dir/mask order
    localparam logic [3:0] SEL_P0_CLR  = 4'd1;
    localparam logic [3:0] SEL_P0_SET  = 4'd2;
    localparam logic [3:0] SEL_P0_PIN  = 4'd3;
    localparam logic [3:0] SEL_P0_DIR  = 4'd4;
    localparam logic [3:0] SEL_P0_MASK = 4'd5;
    localparam logic [3:0] SEL_P1_CLR  = 4'd6;
    localparam logic [3:0] SEL_P1_SET  = 4'd7;
    localparam logic [3:0] SEL_P1_PIN  = 4'd8;
    localparam logic [3:0] SEL_P1_MASK = 4'd10;

    localparam int RANDOM_ITEMS   = 1050;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int REPORT_LIMIT   = 60;
    localparam int DIRECTED_STEPS = 27;

    typedef struct packed {
        logic [31:0] read_data;
        logic        bad_access;
    } bus_response_t;

    // one row of the directed table; known rows carry the response typed in
    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  sel;
        logic [31:0] data;
        logic        known;
        logic [31:0] read_data;
        logic        bad_access;
    } access_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_mode;
    logic [3:0]  s_reg_select;
    logic [31:0] s_write_data;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_read_data;
    logic        m_bad_access;

    gpio_spi_timer_register_model i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_reg_select (s_reg_select),
        .s_write_data (s_write_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .m_bad_access (m_bad_access)
    );

    // shadow copy of the register state, updated as each transaction is accepted
    logic [31:0]          gpio_out   [PORT_COUNT];
    logic [31:0]          gpio_mask  [PORT_COUNT];
    logic [31:0]          gpio_dir   [PORT_COUNT];
    logic                 timer_irq;
    logic [31:0]          shift_shadow;
    logic                 spi_active;
    int                   spi_ticks_seen;
    logic [7:0]           status_shadow;

    bus_response_t expected_responses [$];
    int            error_count;
    int            cycle_count;
    int            sent_count;
    bit            steady;   // no idling on either side while set

    access_row_t directed_steps [DIRECTED_STEPS] = '{
        // reads right after reset
        '{MODE_READ,   SEL_IRQ,        32'h0000_0000, 1'b1, 32'h0, 1'b0},
        '{MODE_READ,   SEL_SPI_STATUS, 32'h0000_0000, 1'b1, 32'h0, 1'b0},
        // software write to read-only spi status
        '{MODE_WRITE,  SEL_SPI_STATUS, 32'hffff_ffff, 1'b1, 32'h0, 1'b1},
        // port 0: protect upper half, then pin/clear/set on the open bits
        '{MODE_WRITE,  SEL_P0_MASK,    32'hffff_0000, 1'b1, 32'h0, 1'b0},
        '{MODE_WRITE,  SEL_P0_PIN,     32'hffff_ffff, 1'b1, 32'h0, 1'b0},
        '{MODE_READ,   SEL_P0_PIN,     32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{MODE_WRITE,  SEL_P0_CLR,     32'h0000_00ff, 1'b1, 32'h0, 1'b0},
        '{MODE_READ,   SEL_P0_SET,     32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{MODE_WRITE,  SEL_P0_SET,     32'h8000_0001, 1'b1, 32'h0, 1'b0},
        '{MODE_WRITE,  SEL_P0_DIR,     32'hffff_ffff, 1'b1, 32'h0, 1'b0},
        '{MODE_READ,   SEL_P0_DIR,     32'h0000_0000, 1'b1, 32'hffff_ffff, 1'b0},
        // port 1 with an open mask, then protect the low half
        '{MODE_WRITE,  SEL_P1_PIN,     32'hffff_ffff, 1'b1, 32'h0, 1'b0},
        '{MODE_READ,   SEL_P1_PIN,     32'h0000_0000, 1'b1, 32'hffff_ffff, 1'b0},
        '{MODE_WRITE,  SEL_P1_MASK,    32'h0000_ffff, 1'b1, 32'h0, 1'b0},
        '{MODE_WRITE,  SEL_P1_CLR,     32'hffff_ffff, 1'b1, 32'h0, 1'b0},
        '{MODE_READ,   SEL_P1_SET,     32'h0000_0000, 1'b0, 32'h0, 1'b0},
        // spi transfer: data write, three ticks, status read clears
        '{MODE_WRITE,  SEL_SPI_DATA,   32'ha5a5_a5a5, 1'b1, 32'h0, 1'b0},
        '{MODE_TICK,   SEL_SPI_DATA,   32'hffff_ffff, 1'b1, 32'h0, 1'b0},
        '{MODE_TICK,   SEL_IRQ,        32'h0000_0000, 1'b1, 32'h0, 1'b0},
        '{MODE_TICK,   SEL_UNUSED_HI,  32'h0000_0000, 1'b1, 32'h0, 1'b0},
        '{MODE_READ,   SEL_SPI_STATUS, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{MODE_READ,   SEL_SPI_STATUS, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
        // irq flag only clears on a written 1 in bit 0
        '{MODE_WRITE,  SEL_IRQ,        32'hffff_fffe, 1'b1, 32'h0, 1'b0},
        '{MODE_WRITE,  SEL_IRQ,        32'h0000_0001, 1'b1, 32'h0, 1'b0},
        // unused mode and unused selectors
        '{MODE_UNUSED, SEL_IRQ,        32'hffff_ffff, 1'b1, 32'h0, 1'b0},
        '{MODE_READ,   SEL_UNUSED_HI,  32'h0000_0000, 1'b1, 32'h0, 1'b0},
        '{MODE_WRITE,  SEL_UNUSED_LO,  32'hffff_ffff, 1'b1, 32'h0, 1'b0}
    };

    // expected response of one access; advances the shadow state
    function automatic bus_response_t apply_register_access(input logic [1:0] mode,
                                                            input logic [3:0] sel,
                                                            input logic [31:0] data);
        bus_response_t resp;
        int            rel;
        int            port;
        gst_fn_t       fn;
        logic [31:0]   open_bits;
        resp = '0;
        rel  = int'(sel) - int'(SEL_PORT_FIRST);
        port = rel / REGS_PER_PORT;
        fn   = gst_fn_t'(rel % REGS_PER_PORT);
        case (mode)
            MODE_READ: begin
                if (sel == SEL_IRQ) begin
                    resp.read_data = {31'b0, timer_irq};
                end else if (sel >= SEL_PORT_FIRST && sel <= SEL_PORT_LAST) begin
                    if (port < PORT_COUNT) begin
                        case (fn)
                            FN_DIR:  resp.read_data = gpio_dir[port];
                            FN_MASK: resp.read_data = gpio_mask[port];
                            default: resp.read_data = gpio_out[port] & ~gpio_mask[port];
                        endcase
                    end
                end else if (sel == SEL_SPI_DATA) begin
                    resp.read_data = shift_shadow;
                end else if (sel == SEL_SPI_STATUS) begin
                    resp.read_data = {24'b0, status_shadow};
                    status_shadow  = '0;
                end
            end
            MODE_WRITE: begin
                if (sel == SEL_IRQ) begin
                    timer_irq = timer_irq & ~data[0];
                end else if (sel >= SEL_PORT_FIRST && sel <= SEL_PORT_LAST) begin
                    if (port < PORT_COUNT) begin
                        open_bits = data & ~gpio_mask[port];
                        case (fn)
                            FN_CLR:  gpio_out[port] = gpio_out[port] & ~open_bits;
                            FN_SET:  gpio_out[port] = gpio_out[port] | open_bits;
                            FN_PIN:  gpio_out[port] = (gpio_out[port] & gpio_mask[port]) | open_bits;
                            FN_DIR:  gpio_dir[port] = data;
                            default: gpio_mask[port] = data;
                        endcase
                    end
                end else if (sel == SEL_SPI_DATA) begin
                    shift_shadow   = data;
                    spi_active     = 1'b1;
                    spi_ticks_seen = 0;
                end else if (sel == SEL_SPI_STATUS) begin
                    resp.bad_access = 1'b1;
                end
            end
            MODE_TICK: begin
                if (spi_active) begin
                    spi_ticks_seen++;
                    if (spi_ticks_seen >= SPI_DONE_TICKS) begin
                        spi_active     = 1'b0;
                        spi_ticks_seen = 0;
                        status_shadow  = SPI_DONE_STATUS;
                    end
                end
                timer_irq = 1'b1;
            end
            default: ;
        endcase
        return resp;
    endfunction

    // mostly no gap, some short ones, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 0;
        else if (r < 9)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic logic [31:0] pick_data();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h1 << $urandom_range(0, 31);
            3:       return ~(32'h1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    // selectors 0..12 evenly, extra weight on gpio, a few unused ones
    function automatic logic [3:0] pick_sel();
        int r;
        r = $urandom_range(0, 19);
        if (r <= 12)
            return 4'(r);
        else if (r <= 17)
            return 4'($urandom_range(SEL_PORT_FIRST, SEL_PORT_LAST));
        else
            return 4'($urandom_range(SEL_UNUSED_LO, SEL_UNUSED_HI));
    endfunction

    function automatic logic [1:0] pick_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return MODE_READ;
        else if (r < 75)
            return MODE_WRITE;
        else if (r < 95)
            return MODE_TICK;
        else
            return MODE_UNUSED;
    endfunction

    // ------------------------------------------------------------------
    // clock and cycle limit
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // a hang anywhere ends the run here
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // result side backpressure: high for a while, then a random stall,
    // except during steady stretches where m_ready just stays high
    // ------------------------------------------------------------------
    initial begin
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
            if (!steady) begin
                m_ready <= 1'b0;
                repeat (1 + idle_len()) @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------
    // result checker: outputs are sampled at the edge before the block's
    // registers update, so each transaction is seen exactly once
    // ------------------------------------------------------------------
    initial begin
        bus_response_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (expected_responses.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: unexpected result, expected none, actual %h/%b",
                                 $time, m_read_data, m_bad_access);
                end else begin
                    want = expected_responses.pop_front();
                    if (m_read_data !== want.read_data) begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display("%0t: read_data mismatch, expected %h, actual %h",
                                     $time, want.read_data, m_read_data);
                    end
                    if (m_bad_access !== want.bad_access) begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display("%0t: bad_access mismatch, expected %b, actual %b",
                                     $time, want.bad_access, m_bad_access);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sender: optional gap, then hold the transaction until accepted;
    // the expectation is formed at the accepting edge
    // ------------------------------------------------------------------
    task automatic send_access(input logic [1:0] mode, input logic [3:0] sel,
                               input logic [31:0] data, input logic known,
                               input logic [31:0] known_rd, input logic known_bad);
        int            gap;
        bus_response_t resp;
        gap = steady ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_mode       <= mode;
        s_reg_select <= sel;
        s_write_data <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        resp = apply_register_access(mode, sel, data);
        // typed-in rows override the predictor, which still tracks the state
        if (known) begin
            resp.read_data  = known_rd;
            resp.bad_access = known_bad;
        end
        expected_responses.push_back(resp);
        sent_count++;
    endtask

    task automatic send(input logic [1:0] mode, input logic [3:0] sel, input logic [31:0] data);
        send_access(mode, sel, data, 1'b0, 32'h0, 1'b0);
    endtask

    // well-formed spi transfer with other traffic mixed in; the interleaved
    // accesses may themselves restart the transfer, which is fine
    task automatic spi_transfer();
        int ticks;
        ticks = 0;
        send(MODE_WRITE, SEL_SPI_DATA, pick_data());
        while (ticks < SPI_DONE_TICKS) begin
            if ($urandom_range(0, 2) == 0) begin
                send(pick_mode(), pick_sel(), pick_data());
            end else begin
                send(MODE_TICK, pick_sel(), pick_data());
                ticks++;
            end
        end
        if ($urandom_range(0, 3) == 0)
            send(MODE_READ, SEL_SPI_DATA, pick_data());
        send(MODE_READ, SEL_SPI_STATUS, pick_data());
        if ($urandom_range(0, 3) == 0)
            send(MODE_READ, SEL_SPI_STATUS, pick_data());
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        error_count    = 0;
        sent_count     = 0;
        steady         = 1'b0;
        for (int p = 0; p < PORT_COUNT; p++) begin
            gpio_out[p]  = '0;
            gpio_mask[p] = '0;
            gpio_dir[p]  = '0;
        end
        timer_irq      = 1'b0;
        shift_shadow   = '0;
        spi_active     = 1'b0;
        spi_ticks_seen = 0;
        status_shadow  = '0;

        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_mode       <= MODE_READ;
        s_reg_select <= SEL_IRQ;
        s_write_data <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (int i = 0; i < DIRECTED_STEPS; i++)
            send_access(directed_steps[i].mode, directed_steps[i].sel, directed_steps[i].data,
                        directed_steps[i].known, directed_steps[i].read_data,
                        directed_steps[i].bad_access);

        // random traffic; every so often switch to a stretch with no idling
        while (sent_count < DIRECTED_STEPS + RANDOM_ITEMS) begin
            if (sent_count % 128 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
                spi_transfer();
            else
                send(pick_mode(), pick_sel(), pick_data());
        end
        steady = 1'b0;
        s_valid <= 1'b0;

        // let every expected transaction come back, then watch for stray ones
        while (expected_responses.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
